[rtl/sfq_pkg.sv]
// ----------------------------------------------------------------------------
// sfq_pkg: shared types and codes of the sortable queue
// Operation and status codes, and the per-cell control word.
// ----------------------------------------------------------------------------
package sfq_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned FILL_W = 5;

  // Operation codes carried by the kind field.
  localparam logic [1:0] KIND_ENQ  = 2'd0;
  localparam logic [1:0] KIND_DEQ  = 2'd1;
  localparam logic [1:0] KIND_SORT = 2'd2;

  // Status codes of a result word.
  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_UNDER      = 2'd1;
  localparam logic [1:0] ST_OVER       = 2'd2;
  localparam logic [1:0] ST_EMPTY_SORT = 2'd3;

  // Control of one cell.
  typedef struct packed {
    logic load;    // take the incoming word
    logic shift;   // take the right neighbor's word
    logic cmp_lo;  // lower end of a compare-exchange pair: keep the minimum
    logic cmp_hi;  // upper end of a compare-exchange pair: keep the maximum
  } cell_ctrl_t;

endpackage

[rtl/sfq_cell.sv]
// ----------------------------------------------------------------------------
// sfq_cell: one storage cell of the queue
// Holds one entry; loads, shifts toward the head, or compare-exchanges
// with a neighbor.
// ----------------------------------------------------------------------------
module sfq_cell
  import sfq_pkg::*;
(
  input  logic                     clk_i,
  input  cell_ctrl_t               ctrl_i,
  input  logic signed [DATA_W-1:0] load_val_i,
  input  logic signed [DATA_W-1:0] left_val_i,
  input  logic signed [DATA_W-1:0] right_val_i,
  output logic signed [DATA_W-1:0] val_o
);

  logic signed [DATA_W-1:0] val_q;
  logic signed [DATA_W-1:0] val_d;

  // Select the next entry value.
  always_comb begin
    val_d = val_q;
    if (ctrl_i.load) begin
      val_d = load_val_i;
    end else if (ctrl_i.shift) begin
      val_d = right_val_i;
    end else if (ctrl_i.cmp_lo) begin
      if (val_q > right_val_i) begin
        val_d = right_val_i;
      end
    end else if (ctrl_i.cmp_hi) begin
      if (left_val_i > val_q) begin
        val_d = left_val_i;
      end
    end
  end

  // Entry register; payload only, no reset.
  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign val_o = val_q;

endmodule

[rtl/sortable_fifo_queue.sv]
// ----------------------------------------------------------------------------
// sortable_fifo_queue: queue of signed words with in-place ascending sort
// Enqueue, dequeue and sort over a row of cells with the head in cell 0.
// ----------------------------------------------------------------------------
// Enqueue and dequeue: result registered in the cycle after accept;
// a new word is taken every cycle while no sort runs and the result is taken.
// Sort of two or more entries: odd-even compare-exchange rounds across
// the cell row, input stalled meanwhile; result posted at the last round.
// Reset empties the queue and clears the result valid flag; entry contents
// and the result payload are not reset.
module sortable_fifo_queue
  import sfq_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [1:0]               kind_i,
  input  logic signed [DATA_W-1:0] value_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic signed [DATA_W-1:0] value_out_o,
  output logic [1:0]               status_o,
  output logic [FILL_W-1:0]        fill_o
);

  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned RW = $clog2(DEPTH);

  logic [CW-1:0] cnt_q, cnt_d;
  logic          busy_q, busy_d;
  logic [RW-1:0] rnd_q, rnd_d;
  logic          out_valid_q, out_valid_d;
  logic signed [DATA_W-1:0] out_value_q, out_value_d;
  logic [1:0]    out_status_q, out_status_d;
  logic [FILL_W-1:0] out_fill_q, out_fill_d;

  logic          accept;
  logic          full;
  logic signed [DATA_W-1:0] cell_val [DEPTH];
  cell_ctrl_t    cell_ctrl [DEPTH];

  assign full       = (cnt_q == CW'(DEPTH));
  assign in_ready_o = !busy_q && (!out_valid_q || out_ready_i);
  assign accept     = in_valid_i && in_ready_o;

  // Operation control and result word.
  always_comb begin
    cnt_d        = cnt_q;
    busy_d       = busy_q;
    rnd_d        = rnd_q;
    out_valid_d  = out_valid_q;
    out_value_d  = out_value_q;
    out_status_d = out_status_q;
    out_fill_d   = out_fill_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (accept) begin
      out_value_d  = '0;
      out_status_d = ST_OK;
      out_valid_d  = 1'b1;
      unique case (kind_i)
        KIND_ENQ: begin
          if (full) begin
            out_status_d = ST_OVER;
          end else begin
            cnt_d = cnt_q + CW'(1);
          end
        end
        KIND_DEQ: begin
          if (cnt_q == '0) begin
            out_status_d = ST_UNDER;
          end else begin
            out_value_d = cell_val[0];
            cnt_d       = cnt_q - CW'(1);
          end
        end
        KIND_SORT: begin
          if (cnt_q == '0) begin
            out_status_d = ST_EMPTY_SORT;
          end else if (cnt_q != CW'(1)) begin
            // Result is posted when the sort finishes.
            out_valid_d = 1'b0;
            busy_d      = 1'b1;
            rnd_d       = '0;
          end
        end
        default: begin
        end
      endcase
      out_fill_d = FILL_W'(cnt_d);
    end else if (busy_q) begin
      rnd_d = rnd_q + RW'(1);
      if (rnd_q == RW'(DEPTH - 1)) begin
        busy_d       = 1'b0;
        out_valid_d  = 1'b1;
        out_value_d  = '0;
        out_status_d = ST_OK;
        out_fill_d   = FILL_W'(cnt_q);
      end
    end
  end

  // Per-cell control: load at the tail, shift on dequeue, and alternate
  // even and odd pairs during a sort.
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      cell_ctrl[i].load   = accept && (kind_i == KIND_ENQ) && !full &&
                            (cnt_q == CW'(i));
      cell_ctrl[i].shift  = accept && (kind_i == KIND_DEQ) && (cnt_q != '0);
      cell_ctrl[i].cmp_lo = busy_q && (rnd_q[0] == 1'(i % 2)) &&
                            (CW'(i + 1) < cnt_q);
      cell_ctrl[i].cmp_hi = busy_q && (i >= 1) && (rnd_q[0] != 1'(i % 2)) &&
                            (CW'(i) < cnt_q);
    end
  end

  // Row of cells with the head in cell 0.
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic signed [DATA_W-1:0] left_val;
    logic signed [DATA_W-1:0] right_val;
    if (g == 0) begin : g_first
      assign left_val = cell_val[g];
    end else begin : g_mid
      assign left_val = cell_val[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign right_val = cell_val[g];
    end else begin : g_inner
      assign right_val = cell_val[g+1];
    end
    sfq_cell u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (cell_ctrl[g]),
      .load_val_i  (value_i),
      .left_val_i  (left_val),
      .right_val_i (right_val),
      .val_o       (cell_val[g])
    );
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      busy_q      <= 1'b0;
      rnd_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      busy_q      <= busy_d;
      rnd_q       <= rnd_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload registers.
  always_ff @(posedge clk_i) begin
    out_value_q  <= out_value_d;
    out_status_q <= out_status_d;
    out_fill_q   <= out_fill_d;
  end

  assign out_valid_o = out_valid_q;
  assign value_out_o = out_value_q;
  assign status_o    = out_status_q;
  assign fill_o      = out_fill_q;

endmodule

[sim/sfq_checker.sv]
// ----------------------------------------------------------------------------
// sfq_checker: result checker for the sortable queue
// Watches both word channels, keeps its own copy of the queue contents,
// predicts the result word of every accepted input word and compares it
// with the oldest prediction when a result word is taken.
// ----------------------------------------------------------------------------
module sfq_checker
  import sfq_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  input  logic                     in_ready_i,
  input  logic [1:0]               kind_i,
  input  logic signed [DATA_W-1:0] value_i,
  input  logic                     out_valid_i,
  input  logic                     out_ready_i,
  input  logic signed [DATA_W-1:0] value_out_i,
  input  logic [1:0]               status_i,
  input  logic [FILL_W-1:0]        fill_i,
  output int unsigned              mismatches_o,
  output int unsigned              pending_o
);

  // One result word as the block should produce it.
  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic [1:0]               status;
    logic [FILL_W-1:0]        fill;
  } queue_result_t;

  // Shadow copy of the queue: circular store, head position and entry count.
  logic signed [DATA_W-1:0] shadow_words [DEPTH];
  int unsigned              shadow_head;
  int unsigned              shadow_count;

  queue_result_t awaited_results [$];
  int unsigned   mismatch_total;

  // Store position of the entry that sits pos places behind the head.
  function automatic int unsigned slot_at(int unsigned pos);
    return (shadow_head + pos) % DEPTH;
  endfunction

  // Bubble sort of the held entries into ascending signed order, head first.
  function automatic void sort_ascending();
    int unsigned              pass_len;
    int unsigned              i;
    int unsigned              lo;
    int unsigned              hi;
    logic signed [DATA_W-1:0] tmp;
    for (pass_len = shadow_count - 1; pass_len > 0; pass_len--) begin
      for (i = 0; i < pass_len; i++) begin
        lo = slot_at(i);
        hi = slot_at(i + 1);
        if (shadow_words[lo] > shadow_words[hi]) begin
          tmp              = shadow_words[lo];
          shadow_words[lo] = shadow_words[hi];
          shadow_words[hi] = tmp;
        end
      end
    end
  endfunction

  // Apply one operation to the shadow queue and return its result word.
  function automatic queue_result_t apply_queue_op(logic [1:0] kind,
                                                   logic signed [DATA_W-1:0] word);
    queue_result_t res;
    res.value  = '0;
    res.status = ST_OK;
    case (kind)
      KIND_ENQ: begin
        if (shadow_count >= DEPTH) begin
          res.status = ST_OVER;
        end else begin
          shadow_words[slot_at(shadow_count)] = word;
          shadow_count++;
        end
      end
      KIND_DEQ: begin
        if (shadow_count == 0) begin
          res.status = ST_UNDER;
        end else begin
          res.value   = shadow_words[shadow_head];
          shadow_head = (shadow_head + 1) % DEPTH;
          shadow_count--;
        end
      end
      KIND_SORT: begin
        if (shadow_count == 0) begin
          res.status = ST_EMPTY_SORT;
        end else begin
          sort_ascending();
        end
      end
      default: begin
        // The unused kind leaves the queue alone.
      end
    endcase
    res.fill = shadow_count[FILL_W-1:0];
    return res;
  endfunction

  // Compare taken result words first, then record the prediction of a new word.
  always @(posedge clk_i or negedge rst_ni) begin : watch
    queue_result_t got;
    queue_result_t want;
    if (!rst_ni) begin
      shadow_head    = 0;
      shadow_count   = 0;
      mismatch_total = 0;
      awaited_results.delete();
      mismatches_o <= 0;
      pending_o    <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        got.value  = value_out_i;
        got.status = status_i;
        got.fill   = fill_i;
        if (awaited_results.size() == 0) begin
          if (mismatch_total < 10) begin
            $display("%0t: unexpected result word: value %0d status %0d fill %0d",
                     $time, got.value, got.status, got.fill);
          end
          mismatch_total++;
        end else begin
          want = awaited_results.pop_front();
          if (got !== want) begin
            if (mismatch_total < 10) begin
              $display("%0t: result mismatch: expected value %0d status %0d fill %0d",
                       $time, want.value, want.status, want.fill);
              $display("%0t: result mismatch: got value %0d status %0d fill %0d",
                       $time, got.value, got.status, got.fill);
            end
            mismatch_total++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        awaited_results.push_back(apply_queue_op(kind_i, value_i));
      end
      mismatches_o <= mismatch_total;
      pending_o    <= awaited_results.size();
    end
  end

endmodule

[sim/testbench.sv]
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the sortable queue
// Drives directed corner cases and then random enqueue, dequeue and sort
// words with random gaps on both channels, including a long receiver
// hold-off and full drains, while the checker predicts and compares.
// ----------------------------------------------------------------------------
module testbench;
  import sfq_pkg::*;

  localparam int unsigned DEPTH        = 16;
  localparam logic [1:0]  KIND_UNUSED  = 2'd3;
  localparam int unsigned RANDOM_WORDS = 1625;
  localparam int unsigned DRAIN_CYCLES = DEPTH + 8;
  localparam int unsigned LONG_HOLD    = 300;

  logic                     clk = 1'b0;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_ready;
  logic [1:0]               in_kind;
  logic signed [DATA_W-1:0] in_value;
  logic                     out_valid;
  logic                     out_ready;
  logic signed [DATA_W-1:0] out_value;
  logic [1:0]               out_status;
  logic [FILL_W-1:0]        out_fill;

  int unsigned mismatches;
  int unsigned pending;
  bit          tx_quiet;
  bit          rx_quiet;
  int unsigned results_taken;

  always #5 clk = ~clk;

  sortable_fifo_queue #(
    .DEPTH(DEPTH)
  ) dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .kind_i     (in_kind),
    .value_i    (in_value),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .value_out_o(out_value),
    .status_o   (out_status),
    .fill_o     (out_fill)
  );

  sfq_checker #(
    .DEPTH(DEPTH)
  ) u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .kind_i      (in_kind),
    .value_i     (in_value),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .value_out_i (out_value),
    .status_i    (out_status),
    .fill_i      (out_fill),
    .mismatches_o(mismatches),
    .pending_o   (pending)
  );

  // Random data word: extremes, small values that tend to repeat, or anything.
  function automatic logic signed [DATA_W-1:0] random_word();
    case ($urandom_range(0, 9))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7fff_ffff;
      2:       return $signed($urandom_range(0, 16)) - 8;
      3:       return $urandom_range(0, 1) ? 32'sh0 : -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  // Offer one word after a random gap and hold it until accepted.
  // Called and returns at a falling edge.
  task automatic send_word(input logic [1:0] kind, input logic signed [DATA_W-1:0] word);
    int unsigned gap;
    gap = tx_quiet ? 0 : $urandom_range(0, 9);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_kind  <= kind;
    in_value <= word;
    do @(posedge clk); while (!(in_valid && in_ready));
    @(negedge clk);
  endtask

  // Stop offering and wait until every predicted result word has been taken.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  // Result side: random stalls per word, quiet stretches and two long hold-offs.
  initial begin : receiver
    int unsigned stall;
    out_ready     = 1'b0;
    results_taken = 0;
    rx_quiet      = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      if (results_taken % 64 == 0) begin
        rx_quiet = ($urandom_range(0, 3) == 0);
      end
      if (results_taken == 400 || results_taken == 1100) begin
        stall = LONG_HOLD;
      end else if (rx_quiet) begin
        stall = 0;
      end else begin
        stall = $urandom_range(0, 9);
      end
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
      results_taken++;
      @(negedge clk);
    end
  end

  // Input side: reset, directed corner cases, random traffic, verdict.
  initial begin : stimulus
    logic signed [DATA_W-1:0] corner_words [6];
    int unsigned              n;
    int unsigned              pick;
    bit                       fill_bias;
    logic [1:0]               op;
    corner_words[0] = 32'sh7fff_ffff;
    corner_words[1] = 32'sh8000_0000;
    corner_words[2] = 32'sh0;
    corner_words[3] = -32'sd1;
    corner_words[4] = 32'sd1;
    corner_words[5] = 32'sh7fff_ffff;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_kind   = KIND_ENQ;
    in_value  = '0;
    tx_quiet  = 1'b0;
    fill_bias = 1'b0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Empty queue: dequeue underflows, sort reports empty, unused kind is a no-op.
    send_word(KIND_DEQ, 32'sd5);
    send_word(KIND_SORT, '0);
    send_word(KIND_UNUSED, 32'sh7fff_ffff);
    // A single entry sorts to itself.
    send_word(KIND_ENQ, 32'sh8000_0000);
    send_word(KIND_SORT, '1);
    send_word(KIND_DEQ, '0);
    // Fill up with extremes and duplicates, overflow, then sort the full queue.
    for (n = 0; n < DEPTH; n++) begin
      send_word(KIND_ENQ, (n < 6) ? corner_words[n] : random_word());
    end
    send_word(KIND_ENQ, 32'sh1234);
    send_word(KIND_SORT, '0);
    wait_drained();

    // Random traffic; the fill level drifts up or down in stretches of 50 words.
    for (n = 0; n < RANDOM_WORDS; n++) begin
      if (n % 50 == 0) begin
        tx_quiet  = ($urandom_range(0, 3) == 0);
        fill_bias = ($urandom_range(0, 1) == 1);
      end
      if (n == 800) begin
        wait_drained();
      end
      pick = $urandom_range(0, 99);
      if (pick < 4) begin
        op = KIND_UNUSED;
      end else if (pick < 12) begin
        op = KIND_SORT;
      end else if (pick < (fill_bias ? 64 : 36)) begin
        op = KIND_ENQ;
      end else begin
        op = KIND_DEQ;
      end
      send_word(op, random_word());
    end
    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Hard stop in case the block hangs or loses a result word.
  initial begin : watchdog
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
